// ===== rtl/core/tpbe_pkg.sv =====
// Shared types, codes and constants of the tape pulse byte encoder.
// No dependencies; every other file of the block but tpbe_check imports this package.
package tpbe_pkg;

    // Input commands, carried on the input tuser
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_PILOT = 3'd1;
    localparam logic [2:0] CMD_SYNC  = 3'd2;
    localparam logic [2:0] CMD_DATA  = 3'd3;
    localparam logic [2:0] CMD_CLOSE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_CODE_MODE   = 2'd0;
    localparam logic [1:0] CFG_PASSTHROUGH = 2'd1;
    localparam logic [1:0] CFG_DIFF_PARITY = 2'd2;
    localparam logic [1:0] CFG_PAGE_SIZE   = 2'd3;

    // Pulse codes
    localparam logic [1:0] MODE_SINGLE_FULL = 2'd0;
    localparam logic [1:0] MODE_DOUBLE_FULL = 2'd1;
    localparam logic [1:0] MODE_SINGLE_HALF = 2'd2;
    localparam logic [1:0] MODE_DOUBLE_HALF = 2'd3;

    localparam logic [7:0] PILOT_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_ODD   = 8'hFC;
    localparam logic [7:0] SYNC_EVEN  = 8'hFE;
    localparam logic [7:0] PARITY_INV = 8'hFF;
    localparam logic [3:0] FULL_USED  = 4'd8;

    // Work handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ENC   = 2'd1,
        OP_CLOSE = 2'd2
    } job_op_t;

    typedef struct packed {
        job_op_t    op;
        logic [7:0] data;
        logic       marker;   // append a page marker after the byte
    } job_t;

    typedef struct packed {
        logic [1:0]  code_mode;
        logic        passthrough;
        logic        diff_parity;
        logic [15:0] page_size;
    } cfg_t;

    // One result beat before run_last is known
    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] used_bits;
        logic       block_end;
    } res_t;

    // Sync and page marker byte for a pulse code
    function automatic logic [7:0] sync_byte(input logic [1:0] mode);
        sync_byte = mode[0] ? SYNC_ODD : SYNC_EVEN;
    endfunction

endpackage

// ===== rtl/core/tpbe_queue.sv =====
// Short job queue between the front and back ends of the encoder.
// Depends on tpbe_pkg for the job type.
module tpbe_queue
    import tpbe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/tpbe_front.sv =====
// Front end: accepts command beats, keeps parity and page count, queues jobs.
// Depends on tpbe_pkg for commands, job and configuration types.
module tpbe_front
    import tpbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] data_byte,
    output logic       q_push,
    output job_t       q_job,
    input  logic       q_full
);

    logic [7:0]  parity_reg;
    logic [7:0]  parity_next;
    logic [15:0] page_count_reg;
    logic [15:0] page_count_next;

    logic        accept;
    logic [7:0]  mixed;
    logic [15:0] page_dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign mixed    = parity_reg ^ data_byte;
    assign page_dec = page_count_reg - 16'd1;

    // Classify the command and build its job
    always_comb
    begin
        parity_next     = parity_reg;
        page_count_next = page_count_reg;
        q_push          = 1'b0;
        q_job.op        = OP_ENC;
        q_job.data      = PILOT_BYTE;
        q_job.marker    = 1'b0;
        unique case (cmd)
            CMD_START:
            begin
                parity_next     = '0;
                page_count_next = cfg.page_size;
                q_push          = accept;
                q_job.op        = OP_CLEAR;
            end
            CMD_PILOT:
            begin
                q_push = accept && !cfg.passthrough;
            end
            CMD_SYNC:
            begin
                q_push     = accept && !cfg.passthrough;
                q_job.data = sync_byte(cfg.code_mode);
            end
            CMD_DATA:
            begin
                q_push      = accept;
                q_job.data  = cfg.diff_parity ? mixed : data_byte;
                parity_next = cfg.diff_parity ? data_byte : mixed;
                if (cfg.page_size != '0)
                begin
                    if (page_dec == '0)
                    begin
                        q_job.marker    = 1'b1;
                        page_count_next = cfg.page_size;
                    end
                    else
                    begin
                        page_count_next = page_dec;
                    end
                end
            end
            CMD_CLOSE:
            begin
                q_push     = accept;
                q_job.op   = OP_CLOSE;
                q_job.data = parity_reg ^ PARITY_INV;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    // Hold the block state across beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg     <= '0;
            page_count_reg <= '0;
        end
        else if (accept)
        begin
            parity_reg     <= parity_next;
            page_count_reg <= page_count_next;
        end
    end

endmodule

// ===== rtl/core/tpbe_back.sv =====
// Back end: turns queued jobs into tape samples, packs them and drives the output.
// Depends on tpbe_pkg; outside passthrough, one bit pair of a byte is encoded per cycle unless stalled.
module tpbe_back
    import tpbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] used_bits, rest zero
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser    // block_end
);

    typedef enum logic [3:0] {
        ST_MAIN  = 4'b0001,
        ST_MARK  = 4'b0010,
        ST_EDGE  = 4'b0100,
        ST_FINAL = 4'b1000
    } eng_state_t;

    eng_state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       level_reg, level_next;
    logic [7:0] pk_data_reg, pk_data_next;
    logic [3:0] pk_cnt_reg, pk_cnt_next;

    logic hold_valid_reg, hold_valid_next;
    logic hold_final_reg, hold_final_next;
    res_t hold_reg, hold_next;
    logic out_valid_reg, out_valid_next;
    logic out_last_reg, out_last_next;
    res_t out_reg, out_next;

    logic       out_free;
    logic       go;
    logic       move;
    logic       emit;
    logic       finish;
    res_t       emit_res;

    logic [7:0] cur_byte;
    logic [1:0] bits2;
    logic [7:0] pat;
    logic [3:0] n;
    logic       flip;
    logic [7:0] seg_a, seg_b;
    logic [3:0] len_a, len_b;
    logic [7:0] samples;
    logic [15:0] merged;
    logic [4:0] sum;
    logic       flush;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign go       = job_valid && (!hold_valid_reg || out_free);
    assign cur_byte = (state_reg == ST_MARK) ? sync_byte(cfg.code_mode) : job.data;

    // Pick the bit pair for this step
    always_comb
    begin
        case (step_reg)
            2'd0:    bits2 = cur_byte[7:6];
            2'd1:    bits2 = cur_byte[5:4];
            2'd2:    bits2 = cur_byte[3:2];
            default: bits2 = cur_byte[1:0];
        endcase
    end

    // Sample pattern relative to the level: 1 means the toggled level
    always_comb
    begin
        seg_a = 8'h80;
        seg_b = 8'h80;
        len_a = 4'd1;
        len_b = 4'd1;
        pat   = 8'h80;
        n     = 4'd1;
        flip  = 1'b1;
        if (state_reg == ST_EDGE)
        begin
            pat  = 8'h80;
            n    = 4'd1;
            flip = 1'b1;
        end
        else
        begin
            unique case (cfg.code_mode)
                MODE_SINGLE_FULL:
                begin
                    seg_a = bits2[1] ? 8'hC0 : 8'h80;
                    len_a = bits2[1] ? 4'd4 : 4'd2;
                    seg_b = bits2[0] ? 8'hC0 : 8'h80;
                    len_b = bits2[0] ? 4'd4 : 4'd2;
                    pat   = seg_a | (seg_b >> len_a);
                    n     = len_a + len_b;
                    flip  = 1'b0;
                end
                MODE_SINGLE_HALF:
                begin
                    len_a = bits2[1] ? 4'd2 : 4'd1;
                    len_b = bits2[0] ? 4'd2 : 4'd1;
                    pat   = ~(8'hFF >> len_a);
                    n     = len_a + len_b;
                    flip  = 1'b0;
                end
                MODE_DOUBLE_FULL:
                begin
                    len_a = {2'b00, bits2} + 4'd1;
                    pat   = ~(8'hFF >> len_a);
                    n     = {len_a[2:0], 1'b0};
                    flip  = 1'b0;
                end
                default:
                begin
                    len_a = {2'b00, bits2} + 4'd1;
                    pat   = ~(8'hFF >> len_a);
                    n     = len_a;
                    flip  = 1'b1;
                end
            endcase
        end
    end

    // Merge the new samples into the packer
    assign samples = (pat ^ {8{level_reg}}) & ~(8'hFF >> n);
    assign merged  = {pk_data_reg, 8'h00} | ({samples, 8'h00} >> pk_cnt_reg);
    assign sum     = {1'b0, pk_cnt_reg} + {1'b0, n};
    assign flush   = (sum > 5'd8);

    // Sequence the current job
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        level_next   = level_reg;
        pk_data_next = pk_data_reg;
        pk_cnt_next  = pk_cnt_reg;
        emit         = 1'b0;
        finish       = 1'b0;
        job_pop      = 1'b0;
        emit_res.out_byte  = merged[15:8];
        emit_res.used_bits = FULL_USED;
        emit_res.block_end = 1'b0;
        if (go)
        begin
            if (job.op == OP_CLEAR)
            begin
                level_next   = 1'b0;
                pk_data_next = '0;
                pk_cnt_next  = '0;
                finish       = 1'b1;
                job_pop      = 1'b1;
            end
            else if (cfg.passthrough)
            begin
                // Emit bytes as they are, packer untouched
                emit               = 1'b1;
                emit_res.out_byte  = cur_byte;
                emit_res.block_end = (job.op == OP_CLOSE);
                if (state_reg == ST_MAIN && job.marker)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_MAIN;
                    finish     = 1'b1;
                    job_pop    = 1'b1;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_MAIN, ST_MARK:
                    begin
                        level_next = level_reg ^ flip;
                        emit       = flush;
                        if (flush)
                        begin
                            pk_data_next = merged[7:0];
                            pk_cnt_next  = sum[3:0] - 4'd8;
                        end
                        else
                        begin
                            pk_data_next = merged[15:8];
                            pk_cnt_next  = sum[3:0];
                        end
                        step_next = step_reg + 2'd1;
                        if (step_reg == 2'd3)
                        begin
                            if (state_reg == ST_MAIN && job.marker)
                            begin
                                state_next = ST_MARK;
                            end
                            else if (state_reg == ST_MAIN && job.op == OP_CLOSE)
                            begin
                                state_next = ST_EDGE;
                            end
                            else
                            begin
                                state_next = ST_MAIN;
                                finish     = 1'b1;
                                job_pop    = 1'b1;
                            end
                        end
                    end
                    ST_EDGE:
                    begin
                        level_next = level_reg ^ flip;
                        emit       = flush;
                        if (flush)
                        begin
                            pk_data_next = merged[7:0];
                            pk_cnt_next  = sum[3:0] - 4'd8;
                        end
                        else
                        begin
                            pk_data_next = merged[15:8];
                            pk_cnt_next  = sum[3:0];
                        end
                        state_next = ST_FINAL;
                    end
                    ST_FINAL:
                    begin
                        // Pad and send the last partial byte
                        emit               = 1'b1;
                        emit_res.out_byte  = pk_data_reg;
                        emit_res.used_bits = pk_cnt_reg;
                        emit_res.block_end = 1'b1;
                        pk_data_next       = '0;
                        pk_cnt_next        = '0;
                        state_next         = ST_MAIN;
                        finish             = 1'b1;
                        job_pop            = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_MAIN;
                    end
                endcase
            end
        end
    end

    // Hold the newest beat until the next one shows whether it ends the run
    assign move = hold_valid_reg && out_free && (hold_final_reg || emit);

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        if (emit)
        begin
            hold_valid_next = 1'b1;
            hold_final_next = finish;
            hold_next       = emit_res;
        end
        else if (move)
        begin
            hold_valid_next = 1'b0;
        end
        else if (finish)
        begin
            hold_final_next = 1'b1;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
            out_next       = hold_reg;
            out_last_next  = hold_final_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_MAIN;
            step_reg       <= '0;
            level_reg      <= 1'b0;
            pk_cnt_reg     <= '0;
            pk_data_reg    <= '0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            level_reg      <= level_next;
            pk_cnt_reg     <= pk_cnt_next;
            pk_data_reg    <= pk_data_next;
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.used_bits, out_reg.out_byte};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_reg.block_end;

endmodule

// ===== rtl/core/tape_pulse_byte_encoder_unit.sv =====
// Tape pulse byte encoder, top level: configuration registers, front end, queue, back end.
// Depends on tpbe_pkg, tpbe_front, tpbe_queue and tpbe_back.
// Outside passthrough the back end encodes one bit pair per cycle unless the output stalls;
// a page marker adds a sync byte, close an edge and a padded last byte; start only clears.
// A queued beat starts in the back end in the cycle after acceptance at the earliest; its last
// result passes the hold and output registers. Reset clears all but the payload registers.
module tape_pulse_byte_encoder_unit
    import tpbe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] used_bits, rest zero
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] block_end
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t cfg_reg;
    logic q_push;
    job_t q_job;
    logic q_full;
    logic job_valid;
    job_t job;
    logic job_pop;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CODE_MODE:   cfg_reg.code_mode   <= cfg_data[1:0];
                CFG_PASSTHROUGH: cfg_reg.passthrough <= cfg_data[0];
                CFG_DIFF_PARITY: cfg_reg.diff_parity <= cfg_data[0];
                CFG_PAGE_SIZE:   cfg_reg.page_size   <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    tpbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .q_push    (q_push),
        .q_job     (q_job),
        .q_full    (q_full)
    );

    tpbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .head_valid (job_valid),
        .head_job   (job),
        .pop        (job_pop)
    );

    tpbe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .job_valid     (job_valid),
        .job           (job),
        .job_pop       (job_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/tpbe_check.sv =====
// Port-level checker for the tape pulse byte encoder, bound to the top level.
// Depends only on the top level's ports.
module tpbe_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Block end always closes the run of its beat
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("block end without run end");

    // Used sample count within one to eight
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:8] != 4'd0 && m_axis_tdata[11:8] <= 4'd8)
        else $error("used sample count out of range");

    // Partial bytes only at block end
    a_partial_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11:8] != 4'd8 |-> m_axis_tuser)
        else $error("partial byte before block end");

    // Padding bits of the output beat stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:12] == 4'd0)
        else $error("output padding not zero");

endmodule

bind tape_pulse_byte_encoder_unit tpbe_check u_check (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for tape_pulse_byte_encoder_unit: directed and random command beats,
// with every result beat checked against a cycle-free encoder model kept in this file.
// Depends on tpbe_pkg and the RTL of the encoder only.
`timescale 1ns / 100ps

module tb_top;
    import tpbe_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 200000;

    // One result beat as the encoder should produce it
    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] used_bits;
        logic       run_last;
        logic       block_end;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [2:0]  s_axis_tuser;   // [2:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] out_byte, [11:8] used_bits, rest zero
    logic        m_axis_tlast;   // run_last
    logic        m_axis_tuser;   // [0] block_end
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Encoder model state and its copy of the registers
    cfg_t        cfg;
    logic [8:0]  packer;
    logic        level;
    logic [7:0]  parity;
    logic [15:0] page_left;

    beat_t expected_beats[$];
    beat_t step_beats[$];
    int    err_count;
    int    cycle_count;
    logic  gaps_on;
    logic  stall_req;

    tape_pulse_byte_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- encoder model

    function automatic void add_beat(logic [7:0] b, logic [3:0] used, logic last_of_block);
        step_beats.push_back('{out_byte: b, used_bits: used, run_last: 1'b0,
                               block_end: last_of_block});
    endfunction

    // Shift one sample in; a full byte leaves only when its successor arrives
    function automatic void push_sample(logic s);
        if (packer[8])
        begin
            add_beat(packer[7:0], FULL_USED, 1'b0);
            packer = 9'd1;
        end
        packer = {packer[7:0], s};
    endfunction

    function automatic void flip_level();
        level = ~level;
        push_sample(level);
    endfunction

    function automatic void hold_level(int n);
        for (int i = 0; i < n; i++)
            push_sample(level);
    endfunction

    function automatic logic [7:0] marker_byte();
        return cfg.code_mode[0] ? SYNC_ODD : SYNC_EVEN;
    endfunction

    function automatic void encode_byte(logic [7:0] b);
        int p;
        if (cfg.passthrough)
        begin
            add_beat(b, FULL_USED, 1'b0);
            return;
        end
        case (cfg.code_mode)
            MODE_SINGLE_FULL:
                for (p = 7; p >= 0; p--)
                begin
                    flip_level();
                    if (b[p])
                    begin
                        hold_level(1);
                        flip_level();
                        hold_level(1);
                    end
                    else
                        flip_level();
                end
            MODE_DOUBLE_FULL:
                for (p = 6; p >= 0; p -= 2)
                begin
                    flip_level();
                    hold_level(int'(b[p+:2]));
                    flip_level();
                    hold_level(int'(b[p+:2]));
                end
            MODE_SINGLE_HALF:
                for (p = 7; p >= 0; p--)
                begin
                    flip_level();
                    if (b[p])
                        hold_level(1);
                end
            default:
                for (p = 6; p >= 0; p -= 2)
                begin
                    flip_level();
                    hold_level(int'(b[p+:2]));
                end
        endcase
    endfunction

    // Work out the result beats of one accepted command beat and queue them
    function automatic void predict_item(logic [2:0] cmd, logic [7:0] d);
        logic [3:0] used;
        beat_t      tail;
        step_beats.delete();
        case (cmd)
            CMD_START:
            begin
                packer    = 9'd1;
                level     = 1'b0;
                parity    = 8'd0;
                page_left = cfg.page_size;
            end
            CMD_PILOT:
                if (!cfg.passthrough)
                    encode_byte(PILOT_BYTE);
            CMD_SYNC:
                if (!cfg.passthrough)
                    encode_byte(marker_byte());
            CMD_DATA:
            begin
                parity = parity ^ d;
                encode_byte(cfg.diff_parity ? parity : d);
                if (cfg.diff_parity)
                    parity = d;
                if (cfg.page_size != 16'd0)
                begin
                    page_left = page_left - 16'd1;
                    if (page_left == 16'd0)
                    begin
                        encode_byte(marker_byte());
                        page_left = cfg.page_size;
                    end
                end
            end
            CMD_CLOSE:
                if (cfg.passthrough)
                    add_beat(parity ^ PARITY_INV, FULL_USED, 1'b1);
                else
                begin
                    used = FULL_USED;
                    encode_byte(parity ^ PARITY_INV);
                    flip_level();
                    // pad the final byte with zeros, counting the padding
                    while (!packer[8])
                    begin
                        used   = used - 4'd1;
                        packer = {packer[7:0], 1'b0};
                    end
                    add_beat(packer[7:0], used, 1'b1);
                    packer = 9'd1;
                end
            default:
                ;
        endcase
        if (step_beats.size() > 0)
        begin
            tail = step_beats.pop_back();
            tail.run_last = 1'b1;
            step_beats.push_back(tail);
        end
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        err_count++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    endtask

    // Compare each result beat with the oldest pending one
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("result beat with none pending", m_axis_tdata, 16'd0);
            else
            begin
                want = expected_beats.pop_front();
                if (m_axis_tdata[7:0] !== want.out_byte)
                    report_mismatch("out_byte", 16'(m_axis_tdata[7:0]), 16'(want.out_byte));
                if (m_axis_tdata[11:8] !== want.used_bits)
                    report_mismatch("used_bits", 16'(m_axis_tdata[11:8]),
                                    16'(want.used_bits));
                if (m_axis_tdata[15:12] !== 4'd0)
                    report_mismatch("tdata padding", 16'(m_axis_tdata[15:12]), 16'd0);
                if (m_axis_tlast !== want.run_last)
                    report_mismatch("run_last", 16'(m_axis_tlast), 16'(want.run_last));
                if (m_axis_tuser !== want.block_end)
                    report_mismatch("block_end", 16'(m_axis_tuser), 16'(want.block_end));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure bursts, and a long hold on request
    initial
    begin
        int gap_left;
        int hold_left;
        gap_left      = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                hold_left = STALL_CYCLES;
                stall_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_axis_tready = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                gap_left      = $urandom_range(1, 9) - 1;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one command beat, hold it until accepted, then predict its results
    task automatic send_item(logic [2:0] cmd, logic [7:0] d);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_item(cmd, d);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_CODE_MODE:   cfg.code_mode   = v[1:0];
            CFG_PASSTHROUGH: cfg.passthrough = v[0];
            CFG_DIFF_PARITY: cfg.diff_parity = v[0];
            default:         cfg.page_size   = v;
        endcase
    endtask

    // Reconfigure only once the encoder has gone quiet
    task automatic set_config(logic [1:0] mode, logic pass, logic diff, logic [15:0] plen);
        wait_drained();
        write_reg(CFG_CODE_MODE, {14'd0, mode});
        write_reg(CFG_PASSTHROUGH, {15'd0, pass});
        write_reg(CFG_DIFF_PARITY, {15'd0, diff});
        write_reg(CFG_PAGE_SIZE, plen);
    endtask

    // Reset settings: every command, extreme bytes, unused commands
    task automatic test_single_full_defaults();
        send_item(CMD_START, 8'h00);
        send_item(CMD_PILOT, 8'hFF);
        send_item(CMD_SYNC, 8'h00);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h5A);
        send_item(CMD_CLOSE, 8'h00);
        send_item(CMD_SPARE_LO, 8'hFF);
        send_item(CMD_SPARE_HI, 8'h00);
    endtask

    // Difference bytes with a page marker after every data byte
    task automatic test_double_half_diff_pages();
        set_config(MODE_DOUBLE_HALF, 1'b0, 1'b1, 16'd1);
        send_item(CMD_START, 8'h00);
        send_item(CMD_SYNC, 8'h00);
        send_item(CMD_DATA, 8'hA5);
        send_item(CMD_DATA, 8'h3C);
        send_item(CMD_CLOSE, 8'h00);
    endtask

    // Bytes go out as they are; pilot and sync vanish
    task automatic test_passthrough();
        set_config(MODE_SINGLE_HALF, 1'b1, 1'b0, 16'd2);
        send_item(CMD_START, 8'h00);
        send_item(CMD_PILOT, 8'h00);
        send_item(CMD_SYNC, 8'h00);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h81);
        send_item(CMD_CLOSE, 8'h00);
    endtask

    task automatic test_double_full_long_page();
        set_config(MODE_DOUBLE_FULL, 1'b0, 1'b0, 16'hFFFF);
        send_item(CMD_START, 8'h00);
        send_item(CMD_DATA, 8'h81);
        send_item(CMD_CLOSE, 8'h00);
    endtask

    // Hold the result side off while beats keep coming, so the input stalls
    task automatic test_receiver_stall();
        set_config(MODE_SINGLE_FULL, 1'b0, 1'b0, 16'd3);
        gaps_on   = 1'b0;
        stall_req = 1'b1;
        send_item(CMD_START, 8'h00);
        for (int k = 0; k < 12; k++)
            send_item(CMD_DATA, 8'($urandom));
        send_item(CMD_CLOSE, 8'h00);
        gaps_on = 1'b1;
    endtask

    // One well-formed block: start (usually), pilot, sync, data, close
    task automatic send_block(int n_data);
        int n_pilot;
        if ($urandom_range(0, 9) != 0)
            send_item(CMD_START, 8'($urandom));
        n_pilot = $urandom_range(1, 3);
        repeat (n_pilot) send_item(CMD_PILOT, 8'($urandom));
        send_item(CMD_SYNC, 8'($urandom));
        repeat (n_data) send_item(CMD_DATA, 8'($urandom));
        send_item(CMD_CLOSE, 8'($urandom));
    endtask

    // Random settings per phase; mostly blocks, some stray commands
    task automatic test_random_blocks();
        int          sent;
        int          n;
        logic [15:0] plen;
        for (int ph = 0; ph < 4; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       plen = 16'd0;
                1:       plen = 16'd1;
                2:       plen = 16'hFFFF;
                3:       plen = 16'($urandom_range(2, 5));
                default: plen = 16'($urandom_range(0, 12));
            endcase
            set_config(2'($urandom_range(0, 3)),
                       (ph == 2) ? 1'b1 : ($urandom_range(0, 4) == 0),
                       1'($urandom_range(0, 1)), plen);
            // no idling in the last phase
            gaps_on = (ph < 3) && ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < 16)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    n = $urandom_range(1, 6);
                    send_block(n);
                    sent += n + 4;
                end
                else
                begin
                    send_item(3'($urandom_range(0, 7)), 8'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = CMD_START;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CODE_MODE;
        cfg_data      = 16'd0;
        err_count     = 0;
        cycle_count   = 0;
        gaps_on       = 1'b1;
        stall_req     = 1'b0;
        cfg           = '0;
        packer        = 9'd1;
        level         = 1'b0;
        parity        = 8'd0;
        page_left     = 16'd0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_full_defaults();
        test_double_half_diff_pages();
        test_passthrough();
        test_double_full_long_page();
        test_receiver_stall();
        test_random_blocks();
        wait_drained();

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
